/* design/olfp_pkg.sv */
`timescale 1ns / 1ps
package olfp_pkg;

	localparam int unsigned DATA_W = 72;

	localparam logic [2:0] KIND_VITALS = 3'd0;
	localparam logic [2:0] KIND_PWM    = 3'd1;
	localparam logic [2:0] KIND_GAIN   = 3'd2;
	localparam logic [2:0] KIND_WAVE   = 3'd3;
	localparam logic [2:0] KIND_PASS   = 3'd4;

	localparam logic [1:0] REG_HEAD = 2'd0;
	localparam logic [1:0] REG_TAIL = 2'd1;
	localparam logic [1:0] REG_PLEN = 2'd2;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [13:0] WAVE_MAX = 14'd4095;
	localparam logic [3:0]  WAVE_LEN = 4'd9;

	typedef enum logic [1:0] {
		PH_HEAD,
		PH_LEN,
		PH_PAYLOAD,
		PH_TAIL
	} phase_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// number field parser: prefix, comma, first number, comma, second number, done or fail
	typedef enum logic [2:0] {
		NP_LETTER,
		NP_COMMA,
		NP_A0,
		NP_A,
		NP_B0,
		NP_B,
		NP_DONE,
		NP_FAIL
	} np_state_t;

	typedef struct packed {
		logic        p_ok;
		logic        g_ok;
		logic        w_ok;
		logic [7:0]  p_a;
		logic [7:0]  p_b;
		logic [7:0]  g_a;
		logic [11:0] red;
		logic [11:0] ir;
	} chk_res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [7:0] acc8(input logic [7:0] v, input logic [7:0] c);
		logic [7:0] d;
		d = c - CH_ZERO;
		return (v << 3) + (v << 1) + d;
	endfunction

endpackage

/* design/olfp_line_mem.sv */
`timescale 1ns / 1ps
module olfp_line_mem #(
	parameter int unsigned DEPTH = 30,
	parameter int unsigned AW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* design/olfp_line_chk.sv */
`timescale 1ns / 1ps
module olfp_line_chk #(
	parameter int unsigned LW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              ch_valid,
	input  logic [7:0]        ch,
	output olfp_pkg::chk_res_t res
);

	olfp_pkg::np_state_t p_q, g_q, p_d, g_d;
	logic [7:0]  pa_q, pb_q, ga_q;
	logic [13:0] rv_q, iv_q;
	logic        w_q;
	logic [LW-1:0] pos_q;
	logic        dig;
	logic [13:0] dv;

	assign dig = olfp_pkg::is_digit(ch);
	assign dv  = {10'd0, ch[3:0] - olfp_pkg::CH_ZERO[3:0]};

	always_comb begin
		p_d = p_q;
		case (p_q)
			olfp_pkg::NP_LETTER: p_d = (ch == olfp_pkg::CH_P) ? olfp_pkg::NP_COMMA
				: olfp_pkg::NP_FAIL;
			olfp_pkg::NP_COMMA: p_d = (ch == olfp_pkg::CH_COMMA) ? olfp_pkg::NP_A0
				: olfp_pkg::NP_FAIL;
			olfp_pkg::NP_A0: p_d = dig ? olfp_pkg::NP_A : olfp_pkg::NP_FAIL;
			olfp_pkg::NP_A: p_d = dig ? olfp_pkg::NP_A
				: (ch == olfp_pkg::CH_COMMA) ? olfp_pkg::NP_B0 : olfp_pkg::NP_FAIL;
			olfp_pkg::NP_B0: p_d = dig ? olfp_pkg::NP_B : olfp_pkg::NP_FAIL;
			olfp_pkg::NP_B: p_d = dig ? olfp_pkg::NP_B : olfp_pkg::NP_DONE;
			olfp_pkg::NP_DONE: p_d = olfp_pkg::NP_DONE;
			default: p_d = olfp_pkg::NP_FAIL;
		endcase
	end

	always_comb begin
		g_d = g_q;
		case (g_q)
			olfp_pkg::NP_LETTER: g_d = (ch == olfp_pkg::CH_G) ? olfp_pkg::NP_COMMA
				: olfp_pkg::NP_FAIL;
			olfp_pkg::NP_COMMA: g_d = (ch == olfp_pkg::CH_COMMA) ? olfp_pkg::NP_A0
				: olfp_pkg::NP_FAIL;
			olfp_pkg::NP_A0: g_d = dig ? olfp_pkg::NP_A : olfp_pkg::NP_FAIL;
			olfp_pkg::NP_A: g_d = dig ? olfp_pkg::NP_A : olfp_pkg::NP_DONE;
			olfp_pkg::NP_DONE: g_d = olfp_pkg::NP_DONE;
			default: g_d = olfp_pkg::NP_FAIL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q   <= olfp_pkg::NP_LETTER;
			g_q   <= olfp_pkg::NP_LETTER;
			w_q   <= 1'b0;
			pos_q <= '0;
		end else if (clear) begin
			p_q   <= olfp_pkg::NP_LETTER;
			g_q   <= olfp_pkg::NP_LETTER;
			w_q   <= 1'b1;
			pos_q <= '0;
		end else if (ch_valid) begin
			p_q <= p_d;
			g_q <= g_d;
			if (pos_q < LW'(4) || (pos_q > LW'(4) && pos_q < LW'(olfp_pkg::WAVE_LEN))) begin
				if (!dig) w_q <= 1'b0;
			end else if (pos_q == LW'(4)) begin
				if (ch != olfp_pkg::CH_COMMA) w_q <= 1'b0;
			end else begin
				w_q <= 1'b0;
			end
			if (pos_q != '1) pos_q <= pos_q + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			pa_q <= '0;
			pb_q <= '0;
			ga_q <= '0;
			rv_q <= '0;
			iv_q <= '0;
		end else if (ch_valid) begin
			if (dig && (p_q == olfp_pkg::NP_A0 || p_q == olfp_pkg::NP_A))
				pa_q <= olfp_pkg::acc8(pa_q, ch);
			if (dig && (p_q == olfp_pkg::NP_B0 || p_q == olfp_pkg::NP_B))
				pb_q <= olfp_pkg::acc8(pb_q, ch);
			if (dig && (g_q == olfp_pkg::NP_A0 || g_q == olfp_pkg::NP_A))
				ga_q <= olfp_pkg::acc8(ga_q, ch);
			if (pos_q < LW'(4))
				rv_q <= (rv_q << 3) + (rv_q << 1) + dv;
			else if (pos_q > LW'(4) && pos_q < LW'(olfp_pkg::WAVE_LEN))
				iv_q <= (iv_q << 3) + (iv_q << 1) + dv;
		end
	end

	always_comb begin
		res.p_ok = (p_q == olfp_pkg::NP_B) || (p_q == olfp_pkg::NP_DONE);
		res.g_ok = (g_q == olfp_pkg::NP_A) || (g_q == olfp_pkg::NP_DONE);
		res.w_ok = w_q && (pos_q == LW'(olfp_pkg::WAVE_LEN))
			&& (rv_q <= olfp_pkg::WAVE_MAX) && (iv_q <= olfp_pkg::WAVE_MAX);
		res.p_a  = pa_q;
		res.p_b  = pb_q;
		res.g_a  = ga_q;
		res.red  = rv_q[11:0];
		res.ir   = iv_q[11:0];
	end

endmodule

/* design/oximeter_link_frame_parser.sv */
`timescale 1ns / 1ps
// Oximeter link frame parser.
// s_tvalid/s_tready/s_tdata take one received link byte per word (tdata = rx_byte).
// Bytes either build a binary frame (head, length, payload, tail) or a text line
// ended by newline. Results leave on m_*: m_tuser is the result kind, m_tlast marks
// the final result caused by the input word, m_tdata carries byte0..byte5, wave_red
// and wave_ir from the lowest bit up.
// cfg_valid/cfg_ready/cfg_index/cfg_data write head_byte (0), tail_byte (1) and
// payload_length (2); cfg_ready is always high. Write only while the block is idle.
// Timing: a frame result appears on m_* the cycle after the word that caused it.
// A newline scans the stored line out of the line memory, one character a cycle,
// until the line ends or a NUL character is read. The block works on one word at a
// time and takes the next word only once its results are delivered, so a stalled
// m_tready holds s_tready low.
// Reset restores the register defaults, empties the line and waits for a head
// byte; the memories are not cleared.
module oximeter_link_frame_parser #(
	parameter int unsigned LINE_CAPACITY = 30,
	parameter int unsigned MAX_PAYLOAD   = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [olfp_pkg::DATA_W-1:0] m_tdata, // byte0..byte5, wave_red, wave_ir
	output logic [2:0]  m_tuser,   // result_kind
	output logic        m_tlast,   // last_of_run
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int unsigned LW  = $clog2(LINE_CAPACITY + 1);
	localparam int unsigned AW  = $clog2(LINE_CAPACITY);
	localparam int unsigned CW  = $clog2(MAX_PAYLOAD + 1);
	localparam int unsigned PIW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic [7:0] head_q, tail_q;
	logic [2:0] plen_q;

	olfp_pkg::phase_t phase_q;
	olfp_pkg::state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [7:0]    pay_q [MAX_PAYLOAD];
	logic [LW-1:0] len_q, idx_q;
	logic          rd_vld_s1, stop_q;

	logic          mv_q, last_q, pend_q;
	logic [2:0]    kind_q;
	logic [olfp_pkg::DATA_W-1:0] data_q;
	logic [7:0]    pend_byte_q;

	logic          in_acc, out_acc, rd_en, scan_done, ch_valid, wr_en, clear;
	logic [7:0]    d, rdata;
	logic [CW-1:0] need, cnt_inc;
	logic [47:0]   vit;
	olfp_pkg::chk_res_t res;

	assign d         = s_tdata;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = mv_q;
	assign m_tdata   = data_q;
	assign m_tuser   = kind_q;
	assign m_tlast   = last_q;
	assign in_acc    = s_tvalid && s_tready;
	assign out_acc   = mv_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 8'd170;
			tail_q <= 8'd85;
			plen_q <= 3'd6;
		end else if (cfg_valid) begin
			case (cfg_index)
				olfp_pkg::REG_HEAD: head_q <= cfg_data;
				olfp_pkg::REG_TAIL: tail_q <= cfg_data;
				olfp_pkg::REG_PLEN: plen_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			olfp_pkg::ST_IDLE: begin
				if (in_acc && phase_q == olfp_pkg::PH_HEAD && d != head_q
					&& d == olfp_pkg::CH_NL) state_d = olfp_pkg::ST_SCAN;
			end
			olfp_pkg::ST_SCAN: begin
				if (scan_done) state_d = olfp_pkg::ST_IDLE;
			end
			default: state_d = olfp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == olfp_pkg::ST_IDLE) && !mv_q;
		scan_done = (state_q == olfp_pkg::ST_SCAN) && !rd_vld_s1
			&& (idx_q >= len_q || stop_q);
		rd_en     = (state_q == olfp_pkg::ST_SCAN) && idx_q < len_q && !stop_q;
		ch_valid  = rd_vld_s1 && !stop_q && rdata != olfp_pkg::CH_NUL;
		clear     = in_acc && state_d == olfp_pkg::ST_SCAN;
		wr_en     = in_acc && phase_q == olfp_pkg::PH_HEAD && d != head_q
			&& d != olfp_pkg::CH_NL && d != olfp_pkg::CH_CR
			&& len_q < LW'(LINE_CAPACITY);
	end

	olfp_line_mem #(.DEPTH(LINE_CAPACITY), .AW(AW)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (len_q[AW-1:0]),
		.wr_data (d),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rdata)
	);

	olfp_line_chk #(.LW(LW)) u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (clear),
		.ch_valid (ch_valid),
		.ch       (rdata),
		.res      (res)
	);

	always_comb begin
		need = (plen_q == 3'd0) ? CW'(1) : CW'(plen_q);
		if (need > CW'(MAX_PAYLOAD)) need = CW'(MAX_PAYLOAD);
		cnt_inc = cnt_q + CW'(1);
	end

	for (genvar i = 0; i < 6; i++) begin : g_vit
		if (i < MAX_PAYLOAD) begin : g_on
			assign vit[i*8 +: 8] = pay_q[i];
		end else begin : g_off
			assign vit[i*8 +: 8] = 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && phase_q == olfp_pkg::PH_PAYLOAD && cnt_q < CW'(MAX_PAYLOAD))
			pay_q[cnt_q[PIW-1:0]] <= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= olfp_pkg::ST_IDLE;
			phase_q   <= olfp_pkg::PH_HEAD;
			cnt_q     <= '0;
			len_q     <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			stop_q    <= 1'b0;
			mv_q      <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (rd_en) idx_q <= idx_q + LW'(1);
			if (rd_vld_s1 && rdata == olfp_pkg::CH_NUL) stop_q <= 1'b1;
			if (clear) begin
				idx_q  <= '0;
				stop_q <= 1'b0;
			end
			if (scan_done) begin
				len_q <= '0;
				mv_q  <= res.p_ok || res.g_ok || res.w_ok;
			end
			if (wr_en) len_q <= len_q + LW'(1);
			if (out_acc) begin
				mv_q   <= pend_q;
				pend_q <= 1'b0;
			end
			if (in_acc) begin
				case (phase_q)
					olfp_pkg::PH_HEAD: begin
						if (d == head_q) phase_q <= olfp_pkg::PH_LEN;
					end
					olfp_pkg::PH_LEN: begin
						if (d == {5'd0, plen_q}) begin
							cnt_q   <= '0;
							phase_q <= olfp_pkg::PH_PAYLOAD;
						end else if (d != head_q) begin
							mv_q    <= 1'b1;
							pend_q  <= 1'b1;
							phase_q <= olfp_pkg::PH_HEAD;
						end
					end
					olfp_pkg::PH_PAYLOAD: begin
						cnt_q <= cnt_inc;
						if (cnt_inc >= need) phase_q <= olfp_pkg::PH_TAIL;
					end
					default: begin
						if (d == tail_q) begin
							mv_q    <= 1'b1;
							phase_q <= olfp_pkg::PH_HEAD;
						end else if (d == head_q) begin
							phase_q <= olfp_pkg::PH_LEN;
						end else begin
							phase_q <= olfp_pkg::PH_HEAD;
						end
					end
				endcase
			end
		end
	end

	// result payload; second passthrough word waits in pend_byte_q
	always_ff @(posedge clk) begin
		if (out_acc && pend_q) begin
			data_q <= {64'd0, pend_byte_q};
			kind_q <= olfp_pkg::KIND_PASS;
			last_q <= 1'b1;
		end
		if (scan_done) begin
			last_q <= 1'b1;
			if (res.p_ok) begin
				kind_q <= olfp_pkg::KIND_PWM;
				data_q <= {56'd0, res.p_b, res.p_a};
			end else if (res.g_ok) begin
				kind_q <= olfp_pkg::KIND_GAIN;
				data_q <= {64'd0, res.g_a};
			end else begin
				kind_q <= olfp_pkg::KIND_WAVE;
				data_q <= {res.ir, res.red, 48'd0};
			end
		end
		if (in_acc && phase_q == olfp_pkg::PH_LEN) begin
			data_q      <= {64'd0, head_q};
			kind_q      <= olfp_pkg::KIND_PASS;
			last_q      <= 1'b0;
			pend_byte_q <= d;
		end
		if (in_acc && phase_q == olfp_pkg::PH_TAIL) begin
			data_q <= {24'd0, vit};
			kind_q <= olfp_pkg::KIND_VITALS;
			last_q <= 1'b1;
		end
	end

endmodule
